@@ rtl/brb_pkg.sv @@
// shared constants for the rotating bitmap blitter
package brb_pkg;

    // panel geometry
    localparam int DISPLAY_COLUMNS = 296;
    localparam int LINE_BYTES      = 16;

    // field widths
    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 9;
    localparam int DIM_W   = 8;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;
    localparam int CNT_W   = 13;
    localparam int OUT_W   = 24;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_START_ROW     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_START_COLUMN  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BITMAP_WIDTH  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_BITMAP_HEIGHT = 2'd3;

    // address arithmetic constants, all modulo 2^16
    localparam logic [ADDR_W-1:0] ORIGIN_BASE = ADDR_W'((DISPLAY_COLUMNS * LINE_BYTES) % 65536);
    localparam logic [ADDR_W-1:0] LINE_STEP   = ADDR_W'(LINE_BYTES % 65536);
    localparam logic [ADDR_W-1:0] GROUP_JUMP  = ADDR_W'((8 * LINE_BYTES + 1) % 65536);

    typedef logic [BYTE_W-1:0] byte_row_t;

endpackage

@@ rtl/bitmap_rotate_blit.sv @@
// rotating bitmap blitter: 8x8 bit transpose and frame buffer address walk
//
// usage:
//   s_ channel takes one bitmap byte per word (s_tdata), in column-by-column
//   order. every eighth byte closes a group; the group is transposed and
//   leaves on the m_ channel as eight frame buffer writes, one per word.
//   m_tdata = {write_data, write_address}, m_tlast marks the eighth write of
//   a group, m_tuser marks the final write of a bitmap that ends on a whole group.
//   cfg_wr_en/cfg_index/cfg_wr_data write start_row, start_column,
//   bitmap_width, bitmap_height; any write restarts the bitmap. write only
//   while the block is idle.
// timing:
//   a byte is accepted every cycle while s_tready is high. the first write of a group
//   appears on m_ once the emitter and then the output register have taken it, then
//   one write per cycle while m_tready holds. the group buffer and the write emitter are
//   double buffered, so the sustained rate is one byte in and one write out per cycle;
//   the eighth byte of a group waits only while the emitter still holds rows
//   of the previous group that cannot move out.
// reset:
//   aresetn low clears the byte count, the emitter and the output valid and
//   loads the register reset values (8x8 bitmap at row 0, column 0).
// stall:
//   a stalled m_ side holds its word; bytes keep flowing until the next
//   group is full, then s_tready drops until the emitter frees up.
module bitmap_rotate_blit
    import brb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    // byte input
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,      // [7:0] source_byte
    // frame buffer writes
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,      // [15:0] write_address, [23:16] write_data
    output logic              m_tlast,      // last_of_group
    output logic              m_tuser       // [0] bitmap_done
);

    // configuration registers
    logic [ROW_W-1:0] start_row_reg;
    logic [COL_W-1:0] start_col_reg;
    logic [DIM_W-1:0] bmp_width_reg;
    logic [DIM_W-1:0] bmp_height_reg;

    // gather side
    byte_row_t        gather_reg [8];
    byte_row_t        gather_next [8];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [2:0]       pos;
    logic [CNT_W-1:0] bmp_size;
    logic             s_fire;
    logic             group_done;
    logic             bmp_last;

    // emitter side
    byte_row_t         em_blk_reg [8];
    logic              em_busy_reg;
    logic [2:0]        em_row_reg;
    logic              em_first_reg;
    logic              em_last_reg;
    logic [ADDR_W-1:0] em_addr_reg;
    logic [ADDR_W-1:0] em_addr_next;
    logic [DIM_W-1:0]  em_hp_reg;
    logic [DIM_W-1:0]  em_hp_next;
    logic [DIM_W-1:0]  hp_inc;
    logic [ADDR_W-1:0] row_addr;
    logic [ADDR_W-1:0] origin;
    logic              em_move;
    logic              em_free;
    logic              load;

    // output register
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    // bitmap size in bytes and start address from the registers
    assign bmp_size = CNT_W'((16'(bmp_width_reg) * 16'(bmp_height_reg)) >> 3);
    assign origin   = ORIGIN_BASE + ADDR_W'(start_row_reg)
                      - ADDR_W'(ADDR_W'(start_col_reg) * LINE_STEP);

    assign pos        = cnt_reg[2:0];
    assign s_fire     = s_tvalid && s_tready;
    assign cnt_next   = cnt_reg + CNT_W'(1);
    assign bmp_last   = cnt_next >= bmp_size;
    assign group_done = (cnt_next[2:0] == 3'd0);

    // emitter moves a row whenever the output register can take it
    assign em_move  = em_busy_reg && (!m_tvalid_reg || m_tready);
    assign em_free  = !em_busy_reg || (em_row_reg == 3'd7 && em_move);
    assign s_tready = (pos != 3'd7) || em_free;
    assign load     = s_fire && group_done;

    // drop byte bits into the group: byte pos feeds bit 7-pos of every row
    always_comb begin
        for (int r = 0; r < 8; r++) begin
            gather_next[r] = gather_reg[r];
            gather_next[r][3'd7 - pos] = s_tdata[7 - r];
        end
    end

    // address walk for the row being issued
    always_comb begin
        if (em_hp_reg == '0) begin
            if (em_first_reg && em_row_reg == 3'd0) begin
                row_addr = em_addr_reg;
            end else begin
                // new column: step back to the top of the next column
                row_addr = em_addr_reg - ADDR_W'(bmp_height_reg[7:3]) + ADDR_W'(1);
            end
        end else if (em_row_reg == 3'd0) begin
            // next group in the same column
            row_addr = em_addr_reg + GROUP_JUMP;
        end else begin
            row_addr = em_addr_reg;
        end
    end

    assign hp_inc = em_hp_reg + DIM_W'(1);

    always_comb begin
        em_addr_next = em_addr_reg;
        em_hp_next   = em_hp_reg;
        if (em_move) begin
            em_addr_next = row_addr - LINE_STEP;
            em_hp_next   = (hp_inc == bmp_height_reg) ? '0 : hp_inc;
        end
        // first group of a bitmap starts from the origin
        if (load && cnt_next == CNT_W'(8)) begin
            em_addr_next = origin;
            em_hp_next   = '0;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_row_reg  <= '0;
            start_col_reg  <= '0;
            bmp_width_reg  <= DIM_W'(8);
            bmp_height_reg <= DIM_W'(8);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_ROW:     start_row_reg  <= cfg_wr_data[ROW_W-1:0];
                CFG_START_COLUMN:  start_col_reg  <= cfg_wr_data[COL_W-1:0];
                CFG_BITMAP_WIDTH:  bmp_width_reg  <= cfg_wr_data[DIM_W-1:0];
                CFG_BITMAP_HEIGHT: bmp_height_reg <= cfg_wr_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // byte counter; a config write or the end of the bitmap restarts it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            cnt_reg <= '0;
        end else if (s_fire) begin
            cnt_reg <= bmp_last ? '0 : cnt_next;
        end
    end

    // group buffer: every bit is rewritten before a group completes
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int r = 0; r < 8; r++) begin
                gather_reg[r] <= gather_next[r];
            end
        end
    end

    // emitter control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_busy_reg  <= 1'b0;
            em_row_reg   <= '0;
            em_first_reg <= 1'b0;
            em_last_reg  <= 1'b0;
            em_addr_reg  <= '0;
            em_hp_reg    <= '0;
        end else begin
            em_addr_reg <= em_addr_next;
            em_hp_reg   <= em_hp_next;
            if (em_move) begin
                em_row_reg <= em_row_reg + 3'd1;
                if (em_row_reg == 3'd7) begin
                    em_busy_reg <= 1'b0;
                end
            end
            if (load) begin
                em_busy_reg  <= 1'b1;
                em_row_reg   <= '0;
                em_first_reg <= (cnt_next == CNT_W'(8));
                em_last_reg  <= bmp_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int r = 0; r < 8; r++) begin
                em_blk_reg[r] <= gather_next[r];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (em_move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_move) begin
            m_tdata_reg <= {em_blk_reg[em_row_reg], row_addr};
            m_tlast_reg <= (em_row_reg == 3'd7);
            m_tuser_reg <= (em_row_reg == 3'd7) && em_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // input only stalls on a full group facing a busy emitter
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (pos == 3'd7 && em_busy_reg))
        else $error("input stalled without a pending group");

    // a completed group always occupies the emitter next cycle
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (em_busy_reg && em_row_reg == 3'd0))
        else $error("group not handed to emitter");

    // bitmap end only on a group's last write
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("bitmap end off a group boundary");

    // idle emitter rests at row zero
    a_idle_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !em_busy_reg |-> (em_row_reg == 3'd0))
        else $error("idle emitter not at row zero");

endmodule

@@ tb/tb_bitmap_rotate_blit.sv @@
// self-checking testbench for bitmap_rotate_blit: random byte streams against a transpose and address-walk predictor
`timescale 1ns / 1ps

module tb_bitmap_rotate_blit;
    import brb_pkg::*;

    localparam int HOLD_CYCLES   = 300;     // long m_ side hold-off so the block backs up
    localparam int SETTLE_CYCLES = 12;      // idle cycles after the last expected write, before a register write
    localparam int CYCLE_LIMIT   = 200000;

    // one frame buffer write as it leaves the m_ channel
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        byte_row_t         data;
        logic              group_end;
        logic              done;
    } fb_write_t;

    // predicts the frame buffer writes and holds those still to arrive
    class frame_write_predictor;
        logic [ROW_W-1:0]  start_row;
        logic [COL_W-1:0]  start_column;
        logic [DIM_W-1:0]  bitmap_width;
        logic [DIM_W-1:0]  bitmap_height;
        byte_row_t         block[8];
        logic [15:0]       byte_count;
        logic [7:0]        height_phase;
        logic [ADDR_W-1:0] target_address;
        fb_write_t         expected_writes[$];
        int                mismatch_count;

        function new();
            start_row      = '0;
            start_column   = '0;
            bitmap_width   = 8'd8;
            bitmap_height  = 8'd8;
            mismatch_count = 0;
            restart();
        endfunction

        // new bitmap: clear counts and the gathered bits, reload the origin
        function void restart();
            foreach (block[i]) block[i] = '0;
            byte_count     = '0;
            height_phase   = '0;
            target_address = ADDR_W'(DISPLAY_COLUMNS * LINE_BYTES + int'(start_row)
                                     - int'(start_column) * LINE_BYTES);
        endfunction

        function void write_register(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] value);
            case (index)
                CFG_START_ROW:     start_row     = value[ROW_W-1:0];
                CFG_START_COLUMN:  start_column  = value[COL_W-1:0];
                CFG_BITMAP_WIDTH:  bitmap_width  = value[DIM_W-1:0];
                CFG_BITMAP_HEIGHT: bitmap_height = value[DIM_W-1:0];
                default: ;
            endcase
            restart();
        endfunction

        function void take_source_byte(byte_row_t source);
            int unsigned bitmap_bytes;
            int unsigned pos;
            logic        last;
            fb_write_t   w;
            bitmap_bytes = (int'(bitmap_width) * int'(bitmap_height)) >> 3;
            pos = byte_count[2:0];
            // byte j of a group lands in bit 7-j of every row
            for (int r = 0; r < 8; r++)
                block[r][7 - pos] = block[r][7 - pos] | source[7 - r];
            byte_count = byte_count + 16'd1;
            last = (byte_count >= bitmap_bytes);
            if (byte_count[2:0] != 3'd0) begin
                // a trailing partial group gives no writes
                if (last) restart();
                return;
            end
            for (int r = 0; r < 8; r++) begin
                if (height_phase == 8'd0) begin
                    // new column: step back, except on the very first write
                    if (!(byte_count == 16'd8 && r == 0))
                        target_address = target_address - ADDR_W'(bitmap_height >> 3)
                                         + ADDR_W'(1);
                end else if (r == 0) begin
                    target_address = target_address + ADDR_W'(8 * LINE_BYTES + 1);
                end
                w.address = target_address;
                w.data    = block[r];
                w.group_end = (r == 7);
                w.done    = (r == 7) && last;
                expected_writes.push_back(w);
                target_address = target_address - ADDR_W'(LINE_BYTES);
                height_phase   = height_phase + 8'd1;
                if (height_phase == bitmap_height) height_phase = '0;
            end
            foreach (block[i]) block[i] = '0;
            if (last) restart();
        endfunction

        function void check_frame_write(fb_write_t got);
            fb_write_t want;
            if (expected_writes.size() == 0) begin
                $error("unexpected frame write: address %h data %h", got.address, got.data);
                mismatch_count++;
                return;
            end
            want = expected_writes.pop_front();
            if (got.address !== want.address) begin
                $error("write_address: expected %h, actual %h", want.address, got.address);
                mismatch_count++;
            end
            if (got.data !== want.data) begin
                $error("write_data: expected %h, actual %h", want.data, got.data);
                mismatch_count++;
            end
            if (got.group_end !== want.group_end) begin
                $error("last_of_group: expected %b, actual %b", want.group_end, got.group_end);
                mismatch_count++;
            end
            if (got.done !== want.done) begin
                $error("bitmap_done: expected %b, actual %b", want.done, got.done);
                mismatch_count++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CIDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata     = '0;    // [7:0] source_byte
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [OUT_W-1:0]  m_tdata;             // [15:0] write_address, [23:16] write_data
    logic              m_tlast;             // last_of_group
    logic              m_tuser;             // [0] bitmap_done

    frame_write_predictor predictor;
    int   send_idle_pct = 0;    // chance per word that the byte source holds back
    int   recv_idle_pct = 0;    // chance per cycle that the frame buffer side stalls
    logic hold_req      = 1'b0; // asks the receiver for one long hold-off
    int   bytes_sent    = 0;
    int   cycle_count   = 0;

    bitmap_rotate_blit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // frame buffer side: checks every accepted word, drives m_tready
    initial begin : receiver
        int        hold_left;
        fb_write_t got;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                got.address   = m_tdata[ADDR_W-1:0];
                got.data      = m_tdata[ADDR_W +: BYTE_W];
                got.group_end = m_tlast;
                got.done      = m_tuser;
                predictor.check_frame_write(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                // long hold-off, the sender keeps pushing meanwhile
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one byte, with random gaps, until the block takes it
    task automatic send_byte(input byte_row_t source);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= source;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predictor.take_source_byte(source);
        bytes_sent++;
    endtask

    task automatic stream_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_byte(($urandom_range(7) == 0) ? {8{1'($urandom)}} : 8'($urandom));
    endtask

    // drop s_tvalid and let every pending write drain before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (predictor.expected_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes all four registers, one per cycle
    task automatic load_geometry(input int row, input int col, input int w, input int h);
        logic [CIDX_W-1:0] index_list[4];
        logic [CFG_W-1:0]  value_list[4];
        index_list = '{CFG_START_ROW, CFG_START_COLUMN, CFG_BITMAP_WIDTH, CFG_BITMAP_HEIGHT};
        // bits above the row, width and height fields carry junk that must be dropped
        value_list = '{{5'($urandom), 4'(row)}, 9'(col),
                       {1'($urandom), 8'(w)}, {1'($urandom), 8'(h)}};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= index_list[i];
            cfg_wr_data <= value_list[i];
            @(posedge aclk);
            predictor.write_register(index_list[i], value_list[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // mostly small bitmaps, now and then an extreme or odd size
    function automatic int pick_dimension();
        case ($urandom_range(9))
            0:       return $urandom_range(255);
            1:       return 248;
            2:       return 8 * $urandom_range(5, 30);
            default: return 8 * $urandom_range(1, 4);
        endcase
    endfunction

    task automatic random_bitmaps(input int item_goal);
        int stop_at;
        int bitmap_bytes;
        int count;
        int w;
        int h;
        int col;
        stop_at = bytes_sent + item_goal;
        while (bytes_sent < stop_at) begin
            w = pick_dimension();
            h = pick_dimension();
            case ($urandom_range(3))
                0:       col = 0;
                1:       col = 295;
                2:       col = $urandom_range(295);
                default: col = $urandom_range(511);
            endcase
            settle();
            load_geometry($urandom_range(15), col, w, h);
            bitmap_bytes = (w * h) / 8;
            if (bitmap_bytes == 0)
                count = $urandom_range(1, 3);
            else if ($urandom_range(4) == 0)
                // broken off anywhere, often mid-group
                count = $urandom_range(1, (bitmap_bytes < 40) ? bitmap_bytes : 40);
            else if (bitmap_bytes <= 32)
                count = bitmap_bytes * $urandom_range(1, 2);
            else if (bitmap_bytes <= 64)
                count = bitmap_bytes;
            else
                // large bitmap: only its first groups
                count = 8 * $urandom_range(2, 8);
            // stay within the byte budget of this phase
            if (count > stop_at - bytes_sent)
                count = stop_at - bytes_sent;
            stream_bytes(count);
        end
    endtask

    initial begin : stimulus
        byte_row_t corner_bytes[8];
        predictor = new();
        corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h7E};
        send_idle_pct = 21;
        recv_idle_pct = 68;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry 8x8: a single group that also ends the bitmap
        foreach (corner_bytes[i]) send_byte(corner_bytes[i]);
        // height below 8 and not a multiple of 8, far corner, two trailing bytes dropped
        settle();
        load_geometry(15, 295, 16, 5);
        stream_bytes(10);
        // zero size: every byte ignored
        settle();
        load_geometry(3, 0, 0, 248);
        stream_bytes(2);
        // largest bitmap, cut off mid-group by the next register write
        settle();
        load_geometry(7, 100, 248, 248);
        stream_bytes(3);

        random_bitmaps(70);
        send_idle_pct = 68;
        recv_idle_pct = 21;
        random_bitmaps(70);

        // no idling, with one long hold-off on the frame buffer side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        load_geometry(2, 40, 16, 16);
        hold_req = 1'b1;
        stream_bytes(64);
        random_bitmaps(40);

        settle();
        if (predictor.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
